@@ src/bust_pkg.sv @@
package bust_pkg;

   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned POSITION_W    = 8;
   localparam int unsigned STATUS_W      = 3;
   localparam int unsigned ENTRY_COUNT_W = 5;
   localparam int unsigned LIMIT_W       = 5;
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;

   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_CONTAINS = 2'd2;
   localparam logic [1:0] CMD_READ     = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd5;

   localparam logic [VALUE_W-1:0] INT_MIN = 32'h8000_0000;

   // register index as decoded from the word address
   localparam logic REG_CAPACITY_LIMIT = 1'b0;
   localparam logic [LIMIT_W-1:0] CAPACITY_LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [VALUE_W-1:0] value;
      logic [POSITION_W-1:0]     position;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      found;
      logic signed [VALUE_W-1:0] read_value;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } rsp_word_type;

endpackage

@@ src/bust_csr.sv @@
module bust_csr
   import bust_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LIMIT_W-1:0]    capacity_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic               hit_limit;

   // word index sits above the byte offset; index one is not a register
   assign hit_limit  = (csr_paddr[2] == REG_CAPACITY_LIMIT);
   assign csr_pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_limit) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CAPACITY_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata     = hit_limit ? CSR_DATA_W'(limit_ff) : '0;
   assign capacity_limit = limit_ff;

endmodule

@@ src/bounded_unique_set_table.sv @@
// Table of up to CAPACITY distinct 32-bit values kept packed in insertion order in a
// single-port-read, single-port-write entry RAM. One command is handled at a time; req_stall
// stays high until its response word has been loaded into the output register. Every entry
// visit costs one RAM read. A command rejected outright (full, empty, index out of range) goes
// straight to the response state; a read at an index makes a single RAM read; insert, contains
// and remove scan the live entries, and a remove then moves its later entries down one per
// cycle. Entries hold no reset value and need no clearing pass.
module bounded_unique_set_table
   import bust_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_READ,
      S_RESP
   } state_type;

   logic [LIMIT_W-1:0] capacity_limit;

   bust_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .capacity_limit (capacity_limit)
   );

   state_type          state_ff, state_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]   src_ff, src_in;
   logic               mv_vld_ff, mv_vld_in;
   logic [IDX_W-1:0]   mv_dst_ff, mv_dst_in;
   rsp_word_type       res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;

   logic               full;
   logic               pos_ok;
   logic               hit;
   logic [CNT_W-1:0]   src_dec;
   logic [CNT_W-1:0]   count_inc;
   logic [CNT_W-1:0]   count_dec;

   assign full = (CMP_W'(count_ff) >= CMP_W'(capacity_limit))
              || (CMP_W'(count_ff) >= CMP_W'(CAPACITY));
   assign pos_ok    = CMP_W'(req_word.position) < CMP_W'(count_ff);
   assign hit       = chk_vld_ff && (rd_data_ff == value_ff);
   assign src_dec   = src_ff - CNT_W'(1);
   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      src_in       = src_ff;
      mv_vld_in    = 1'b0;
      mv_dst_in    = mv_dst_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in             = req_word.cmd;
               value_in           = req_word.value;
               iss_in             = '0;
               res_in.status      = ST_OK;
               res_in.found       = 1'b0;
               res_in.read_value  = '0;
               res_in.entry_count = ENTRY_COUNT_W'(count_ff);
               unique case (req_word.cmd)
                  CMD_INSERT: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_CONTAINS: begin
                     state_in = S_SCAN;
                  end
                  CMD_READ: begin
                     if (pos_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_word.position[IDX_W-1:0];
                        state_in = S_READ;
                     end else begin
                        res_in.status     = ST_RANGE;
                        res_in.read_value = INT_MIN;
                        state_in          = S_RESP;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (hit) begin
               if (cmd_ff == CMD_INSERT) begin
                  res_in.status = ST_DUPLICATE;
                  state_in      = S_RESP;
               end else if (cmd_ff == CMD_REMOVE) begin
                  src_in   = CNT_W'(chk_idx_ff) + CNT_W'(1);
                  state_in = S_SHIFT;
               end else begin
                  res_in.found = 1'b1;
                  state_in     = S_RESP;
               end
            end else if (!chk_vld_ff && (iss_ff == count_ff)) begin
               // every live entry checked without a match
               if (cmd_ff == CMD_INSERT) begin
                  wr_en              = 1'b1;
                  wr_addr            = count_ff[IDX_W-1:0];
                  count_in           = count_inc;
                  res_in.entry_count = ENTRY_COUNT_W'(count_inc);
               end else if (cmd_ff == CMD_REMOVE) begin
                  res_in.status = ST_NOT_FOUND;
               end
               state_in = S_RESP;
            end else if (iss_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = iss_ff[IDX_W-1:0];
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[IDX_W-1:0];
               iss_in     = iss_ff + CNT_W'(1);
            end
         end

         S_SHIFT: begin
            // read one place up, write it back one place down on the next cycle
            if (mv_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = mv_dst_ff;
               wr_data = rd_data_ff;
            end
            if (src_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = src_ff[IDX_W-1:0];
               mv_vld_in = 1'b1;
               mv_dst_in = src_dec[IDX_W-1:0];
               src_in    = src_ff + CNT_W'(1);
            end else if (!mv_vld_ff) begin
               count_in           = count_dec;
               res_in.entry_count = ENTRY_COUNT_W'(count_dec);
               state_in           = S_RESP;
            end
         end

         S_READ: begin
            res_in.read_value = rd_data_ff;
            state_in          = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         mv_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         mv_vld_ff    <= mv_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      iss_ff      <= iss_in;
      chk_idx_ff  <= chk_idx_in;
      src_ff      <= src_in;
      mv_dst_ff   <= mv_dst_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_move_in_shift: assert property (@(posedge clock) disable iff (reset)
      mv_vld_ff |-> (state_ff == S_SHIFT))
      else $error("entry move pending outside shift");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write to the same entry in one cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cmd_ff == CMD_INSERT && wr_en)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance the count");
`endif

endmodule

@@ tb/bounded_unique_set_table_tb.sv @@
module bounded_unique_set_table_tb
   import bust_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = 16;
   localparam int POOL_SIZE     = 24;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SCRIPT_LEN    = 20;
   localparam int PHASE_COUNT   = 7;
   localparam int REPORT_MAX    = 10;

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR  = {REG_CAPACITY_LIMIT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] BEYOND_ADDR = 3'd4;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [VALUE_W-1:0]       value;
      logic [POSITION_W-1:0]    position;
      logic                     typed;
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic [VALUE_W-1:0]       read_value;
      logic [ENTRY_COUNT_W-1:0] count;
   } script_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow copy of the table
   logic [VALUE_W-1:0] shadow_entries [TABLE_DEPTH];
   int unsigned        shadow_count;
   logic [LIMIT_W-1:0] shadow_limit;

   rsp_word_type       awaited_words [$];
   logic [VALUE_W-1:0] value_pool [POOL_SIZE];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;

   int phase_limit      [PHASE_COUNT] = '{16, 1, 0, 31, 7, 12, 16};
   int phase_idle_pct   [PHASE_COUNT] = '{0, 83, 0, 8, 0, 83, 0};
   int phase_stall_pct  [PHASE_COUNT] = '{0, 0, 83, 8, 0, 0, 83};
   int phase_insert_pct [PHASE_COUNT] = '{55, 45, 45, 45, 45, 50, 50};
   int phase_items      [PHASE_COUNT] = '{400, 150, 100, 400, 250, 150, 200};

   script_row_type script_rows [SCRIPT_LEN] = '{
      '{CMD_READ,     32'h0000_0000, 8'd0,   1'b1, ST_RANGE,     1'b0, INT_MIN, 5'd0},
      '{CMD_REMOVE,   32'h0000_0005, 8'd0,   1'b1, ST_EMPTY,     1'b0, 32'h0,   5'd0},
      '{CMD_CONTAINS, 32'h0000_0000, 8'd0,   1'b1, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_INSERT,   32'h8000_0000, 8'd0,   1'b1, ST_OK,        1'b0, 32'h0,   5'd1},
      '{CMD_INSERT,   32'h7FFF_FFFF, 8'd0,   1'b1, ST_OK,        1'b0, 32'h0,   5'd2},
      '{CMD_INSERT,   32'h0000_0000, 8'd0,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_INSERT,   32'hFFFF_FFFF, 8'd0,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_INSERT,   32'h7FFF_FFFF, 8'd0,   1'b1, ST_DUPLICATE, 1'b0, 32'h0,   5'd4},
      '{CMD_CONTAINS, 32'h8000_0000, 8'd0,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_READ,     32'h0000_0000, 8'd255, 1'b1, ST_RANGE,     1'b0, INT_MIN, 5'd4},
      '{CMD_READ,     32'h0000_0000, 8'd3,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_READ,     32'h0000_0000, 8'd4,   1'b1, ST_RANGE,     1'b0, INT_MIN, 5'd4},
      '{CMD_REMOVE,   32'h7FFF_FFFF, 8'd0,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_READ,     32'h0000_0000, 8'd1,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_REMOVE,   32'h0000_3039, 8'd0,   1'b1, ST_NOT_FOUND, 1'b0, 32'h0,   5'd3},
      '{CMD_REMOVE,   32'hFFFF_FFFF, 8'd0,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_REMOVE,   32'h8000_0000, 8'd0,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_READ,     32'h0000_0000, 8'd0,   1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_CONTAINS, 32'h5555_5555, 8'd170, 1'b0, ST_OK,        1'b0, 32'h0,   5'd0},
      '{CMD_READ,     32'hAAAA_AAAA, 8'd1,   1'b1, ST_RANGE,     1'b0, INT_MIN, 5'd1}
   };

   bounded_unique_set_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned find_value(logic [VALUE_W-1:0] v);
      int unsigned k;
      for (k = 0; k < shadow_count; k++) begin
         if (shadow_entries[k] == v) return k;
      end
      return shadow_count;
   endfunction

   // work out the response word and advance the shadow table
   function automatic rsp_word_type apply_command(req_word_type w);
      rsp_word_type r;
      int unsigned  lim;
      int unsigned  k;
      r = '0;
      lim = (shadow_limit < TABLE_DEPTH) ? shadow_limit : TABLE_DEPTH;
      case (w.cmd)
         CMD_INSERT: begin
            if (shadow_count >= lim) begin
               r.status = ST_FULL;
            end else if (find_value(w.value) < shadow_count) begin
               r.status = ST_DUPLICATE;
            end else begin
               shadow_entries[shadow_count] = w.value;
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               k = find_value(w.value);
               if (k >= shadow_count) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  // close the gap
                  for (; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k + 1];
                  shadow_count--;
               end
            end
         end
         CMD_CONTAINS: begin
            r.found = (find_value(w.value) < shadow_count);
         end
         CMD_READ: begin
            if (w.position < shadow_count) begin
               r.read_value = shadow_entries[w.position];
            end else begin
               r.status = ST_RANGE;
               r.read_value = INT_MIN;
            end
         end
      endcase
      r.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
      return r;
   endfunction

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
   endfunction

   task automatic send_word(req_word_type w, bit use_typed, rsp_word_type typed_rsp);
      rsp_word_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predicted = apply_command(w);
      awaited_words.push_back(use_typed ? typed_rsp : predicted);
   endtask

   // drop valid, then hold until every response word is back
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(bit wr, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_limit_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, addr, data, rd);
      if (addr == LIMIT_ADDR) shadow_limit = data[LIMIT_W-1:0];
      csr_access(1'b0, LIMIT_ADDR, '0, rd);
      if (rd[LIMIT_W-1:0] !== shadow_limit)
         note_mismatch($sformatf("capacity_limit readback: expected %0d, got %0d",
                                 shadow_limit, rd[LIMIT_W-1:0]));
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_words.size() == 0) begin
            note_mismatch($sformatf("unexpected word: status %0d found %0d value %h count %0d",
                                    rsp_word.status, rsp_word.found, rsp_word.read_value,
                                    rsp_word.entry_count));
         end else begin
            exp_w = awaited_words.pop_front();
            if (rsp_word.status !== exp_w.status || rsp_word.found !== exp_w.found ||
                rsp_word.read_value !== exp_w.read_value ||
                rsp_word.entry_count !== exp_w.entry_count)
               note_mismatch($sformatf(
                  "expected status %0d found %0d value %h count %0d, got %0d %0d %h %0d",
                  exp_w.status, exp_w.found, exp_w.read_value, exp_w.entry_count,
                  rsp_word.status, rsp_word.found, rsp_word.read_value, rsp_word.entry_count));
         end
      end
   end

   initial begin
      req_word_type   w;
      script_row_type row;
      int             p;
      int             n;
      int             r;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_word    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      shadow_count = 0;
      shadow_limit = CAPACITY_LIMIT_RESET;
      for (n = 0; n < TABLE_DEPTH; n++) shadow_entries[n] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_limit_register(LIMIT_ADDR, 16);
      for (n = 0; n < SCRIPT_LEN; n++) begin
         row = script_rows[n];
         w.cmd      = row.cmd;
         w.value    = row.value;
         w.position = row.position;
         send_word(w, row.typed, '{row.status, row.found, row.read_value, row.count});
      end
      wait_for_idle();

      for (p = 0; p < PHASE_COUNT; p++) begin
         set_limit_register(LIMIT_ADDR, phase_limit[p]);
         // a write beyond the register list must leave the limit alone
         if (p == 4) set_limit_register(BEYOND_ADDR, 3);
         sender_idle_pct    = phase_idle_pct[p];
         receiver_stall_pct = phase_stall_pct[p];
         value_pool[0] = INT_MIN;
         value_pool[1] = 32'h7FFF_FFFF;
         value_pool[2] = 32'h0000_0000;
         value_pool[3] = 32'hFFFF_FFFF;
         for (n = 4; n < POOL_SIZE; n++) value_pool[n] = $urandom;
         for (n = 0; n < phase_items[p]; n++) begin
            if (p == 3 && n == phase_items[p] / 2) wait_for_idle();
            r = $urandom_range(0, 99);
            if (r < phase_insert_pct[p])           w.cmd = CMD_INSERT;
            else if (r < phase_insert_pct[p] + 25) w.cmd = CMD_REMOVE;
            else if (r < phase_insert_pct[p] + 40) w.cmd = CMD_CONTAINS;
            else                                   w.cmd = CMD_READ;
            w.value = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : $urandom;
            r = $urandom_range(0, 99);
            if (w.cmd != CMD_READ || r >= 90)
               w.position = POSITION_W'($urandom_range(0, 255));
            else if (r < 70)
               w.position = POSITION_W'($urandom_range(0, shadow_count));
            else
               w.position = POSITION_W'($urandom_range(0, TABLE_DEPTH));
            send_word(w, 1'b0, '0);
         end
         wait_for_idle();
      end

      if (mismatch_count == 0 && awaited_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/bust_pkg.sv
src/bust_csr.sv
src/bounded_unique_set_table.sv
tb/bounded_unique_set_table_tb.sv
